[hdl/utf8_stream_decoder_macros.svh]
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent property, sampled on clk, off while rst_n is low.
`define UTF8SD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utf8 decoder: assertion failed");
// Expression that must never be true on a clock edge.
`define UTF8SD_NEVER(lbl, expr) \
    `UTF8SD_ASSERT(lbl, !(expr))
`else
`define UTF8SD_ASSERT(lbl, prop)
`define UTF8SD_NEVER(lbl, expr)
`endif

`endif

[hdl/utf8sd_pkg.sv]
// Package: types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8sd_pkg;

    localparam int CP_W     = 21;
    localparam int BYTE_W   = 8;
    localparam int QCOUNT_W = 2;

    localparam logic [CP_W-1:0] REPL_RESET = 21'd63;  // '?'

    // byte class boundaries (inclusive upper bounds)
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

    // pending continuation counts
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    localparam logic [QCOUNT_W-1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              string_last;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            run_last;
        logic            string_end;
    } result_t;

    // results of one byte, first two slots, count 0..2
    typedef struct packed {
        logic [QCOUNT_W-1:0] count;
        result_t             first;
        result_t             second;
    } dec_out_t;

endpackage

[hdl/utf8sd_decode.sv]
// Byte decoder: pending count, accumulator and per-byte result generation.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module utf8sd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  utf8sd_pkg::item_t          item,
    input  logic                       consume,
    input  logic [utf8sd_pkg::CP_W-1:0] repl_char,
    output utf8sd_pkg::dec_out_t       dec
);

    logic [1:0]                  pend_reg, pend_next;
    logic [utf8sd_pkg::CP_W-1:0] acc_reg, acc_next;
    utf8sd_pkg::result_t         res [0:1];
    logic [1:0]                  n;
    logic [1:0]                  n_m1;
    utf8sd_pkg::result_t         repl_res;
    utf8sd_pkg::result_t         char_res;
    logic [7:0]                  c;

    assign c = item.data_byte;

    always_comb
    begin
        repl_res = '{code_point: repl_char, replaced: 1'b1,
                     run_last: 1'b0, string_end: 1'b0};
        char_res = '{code_point: {13'd0, c}, replaced: 1'b0,
                     run_last: 1'b0, string_end: 1'b0};
        res[0]    = '0;
        res[1]    = '0;
        n         = 2'd0;
        pend_next = pend_reg;
        acc_next  = acc_reg;

        priority if (c <= utf8sd_pkg::ASCII_MAX)
        begin
            if (pend_reg != utf8sd_pkg::PEND_NONE)
            begin
                res[0]    = repl_res;
                n         = 2'd1;
                pend_next = utf8sd_pkg::PEND_NONE;
            end
            res[n[0]] = char_res;
            n         = n + 2'd1;
        end
        else if (c <= utf8sd_pkg::CONT_MAX)
        begin
            if (pend_reg != utf8sd_pkg::PEND_NONE)
            begin
                acc_next  = {acc_reg[14:0], c[5:0] & utf8sd_pkg::CONT_MASK[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_next == utf8sd_pkg::PEND_NONE)
                begin
                    res[0] = '{code_point: acc_next, replaced: 1'b0,
                               run_last: 1'b0, string_end: 1'b0};
                    n      = 2'd1;
                end
            end
            else
            begin
                res[0] = repl_res;
                n      = 2'd1;
            end
        end
        else if (c <= utf8sd_pkg::LEAD2_MAX)
        begin
            pend_next = utf8sd_pkg::PEND_ONE;
            acc_next  = {13'd0, c & utf8sd_pkg::LEAD2_MASK};
        end
        else if (c <= utf8sd_pkg::LEAD3_MAX)
        begin
            pend_next = utf8sd_pkg::PEND_TWO;
            acc_next  = {13'd0, c & utf8sd_pkg::LEAD3_MASK};
        end
        else if (c <= utf8sd_pkg::LEAD4_MAX)
        begin
            pend_next = utf8sd_pkg::PEND_THREE;
            acc_next  = {13'd0, c & utf8sd_pkg::LEAD4_MASK};
        end
        else
        begin
            res[0]    = repl_res;
            n         = 2'd1;
            pend_next = utf8sd_pkg::PEND_NONE;
        end

        // string end: flush an unfinished sequence, restart clean
        if (item.string_last)
        begin
            if (pend_next != utf8sd_pkg::PEND_NONE)
            begin
                res[n[0]] = repl_res;
                n         = n + 2'd1;
            end
            pend_next = utf8sd_pkg::PEND_NONE;
            acc_next  = '0;
        end

        n_m1 = n - 2'd1;
        if (n != 2'd0)
        begin
            res[n_m1[0]].run_last   = 1'b1;
            res[n_m1[0]].string_end = item.string_last;
        end

        dec.count  = n;
        dec.first  = res[0];
        dec.second = res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= utf8sd_pkg::PEND_NONE;
            acc_reg  <= '0;
        end
        else if (consume)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
        end
    end

    `UTF8SD_ASSERT(a_last_clears_state,
        consume && item.string_last |=>
            pend_reg == utf8sd_pkg::PEND_NONE && acc_reg == '0)
    `UTF8SD_ASSERT(a_last_gives_result,
        consume && item.string_last |-> dec.count != 2'd0)
    `UTF8SD_NEVER(a_two_only_after_pending,
        consume && dec.count == 2'd2 && pend_reg == utf8sd_pkg::PEND_NONE)

endmodule

[hdl/utf8sd_result_queue.sv]
// Two-entry result queue between the decoder and the output channel.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module utf8sd_result_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  utf8sd_pkg::dec_out_t               push,
    input  logic                               pop,
    output utf8sd_pkg::result_t                head,
    output logic [utf8sd_pkg::QCOUNT_W-1:0]    count
);

    utf8sd_pkg::result_t                q_reg [0:1];
    utf8sd_pkg::result_t                q_next [0:1];
    logic [utf8sd_pkg::QCOUNT_W-1:0]    count_reg, count_next;
    logic [utf8sd_pkg::QCOUNT_W-1:0]    base;

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        base = count_reg - {1'b0, pop};
        if (push.count != 2'd0)
        begin
            q_next[base[0]] = push.first;
        end
        if (push.count == 2'd2)
        begin
            q_next[1] = push.second;
        end
        count_next = base + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    assign head  = q_reg[0];
    assign count = count_reg;

    `UTF8SD_NEVER(a_no_overflow,
        {1'b0, count_reg} + {1'b0, push.count} > {1'b0, utf8sd_pkg::QUEUE_DEPTH})
    `UTF8SD_NEVER(a_no_pop_empty, pop && count_reg == '0)

endmodule

[hdl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: ports, input and config registers.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

// UTF-8 stream decoder. Takes one byte per input transfer (data_byte, with
// string_last on the final byte of a string) and gives decoded code points,
// each with replaced (malformed input), run_last (last result of this byte)
// and string_end (last result of the string). A byte gives zero, one or two
// results; two only when an ASCII byte cuts an unfinished sequence short.
// Throughput is one byte per cycle while bytes give at most one result each
// and the output side keeps up. A byte is held in the input register until
// the two-entry result queue has room for all its results, so a two-result
// byte waits for the queue to empty and the byte behind it waits for a free
// slot. A byte is decoded from the input register and its results are
// registered in the result queue, whose head drives the output. The
// malformed-input code point is set through the cfg channel (reset 63, '?');
// cfg_ready is always high, and the register must only be written while no
// byte is in flight.
module utf8_stream_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    // byte input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        string_last,
    // code point output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [utf8sd_pkg::CP_W-1:0] code_point,
    output logic                        replaced,
    output logic                        run_last,
    output logic                        string_end,
    // replacement character write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [utf8sd_pkg::CP_W-1:0] cfg_data
);

    utf8sd_pkg::item_t                  item_reg;
    logic                               in_full_reg;
    logic [utf8sd_pkg::CP_W-1:0]        repl_reg;
    utf8sd_pkg::dec_out_t               dec;
    utf8sd_pkg::dec_out_t               push;
    utf8sd_pkg::result_t                head;
    logic [utf8sd_pkg::QCOUNT_W-1:0]    q_count;
    logic                               consume;
    logic                               pop;
    logic                               in_xfer;

    // Byte leaves the input register only when all its results fit; uses
    // registered queue occupancy so no path runs from out_stall to in_stall.
    assign consume  = in_full_reg && (dec.count <= (utf8sd_pkg::QUEUE_DEPTH - q_count));
    assign in_stall = in_full_reg && !consume;
    assign in_xfer  = in_valid && !in_stall;

    assign pop       = (q_count != '0) && !out_stall;
    assign out_valid = (q_count != '0);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_full_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= '{data_byte: data_byte, string_last: string_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= utf8sd_pkg::REPL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            repl_reg <= cfg_data;
        end
    end

    utf8sd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_reg),
        .consume   (consume),
        .repl_char (repl_reg),
        .dec       (dec)
    );

    // results enter the queue only with the byte that made them
    always_comb
    begin
        push = dec;
        if (!consume)
        begin
            push.count = '0;
        end
    end

    utf8sd_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign code_point = head.code_point;
    assign replaced   = head.replaced;
    assign run_last   = head.run_last;
    assign string_end = head.string_end;

    `UTF8SD_NEVER(a_stall_needs_byte, in_stall && !in_full_reg)
    `UTF8SD_ASSERT(a_held_byte_moves_when_drained,
        in_full_reg && q_count == '0 |-> consume)

endmodule

[tb/sv/tb.sv]
// Testbench for the UTF-8 stream decoder: directed table, then random checked byte streams.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 9;
    localparam int TAIL_CYCLES = 8;      // covers the input register and result queue plus lead bytes in flight
    localparam int LONG_HOLD   = 300;    // receiver hold-off, long enough to back up the input
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES  = 8;
    localparam int CYCLE_LIMIT = 400000;

    // one row of byte stimulus; typed rows carry their expected results
    typedef struct packed {
        logic [utf8sd_pkg::BYTE_W-1:0] b;
        logic                          last;
        logic                          typed;
        logic [1:0]                    n;
        utf8sd_pkg::result_t           r0;
        utf8sd_pkg::result_t           r1;
    } byte_row_t;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic [7:0]                  data_byte   = '0;
    logic                        string_last = 1'b0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [utf8sd_pkg::CP_W-1:0] code_point;
    logic                        replaced;
    logic                        run_last;
    logic                        string_end;
    logic                        cfg_valid   = 1'b0;
    logic                        cfg_ready;
    logic [utf8sd_pkg::CP_W-1:0] cfg_data    = '0;

    // decoder state mirror
    logic [1:0]                  pend_cnt = utf8sd_pkg::PEND_NONE;
    logic [utf8sd_pkg::CP_W-1:0] acc_cp   = '0;
    logic [utf8sd_pkg::CP_W-1:0] repl_cp  = utf8sd_pkg::REPL_RESET;
    utf8sd_pkg::result_t         pred_res [2];
    int                          pred_n;

    utf8sd_pkg::result_t         exp_cp_q [$];
    byte_row_t                   byte_table [$];

    int              err_count   = 0;
    int              bytes_sent  = 0;
    int              cps_seen    = 0;
    int              cycle_cnt   = 0;
    bit              fast_mode   = 1'b0;
    bit              hold_out    = 1'b0;

    utf8_stream_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .string_last (string_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .replaced    (replaced),
        .run_last    (run_last),
        .string_end  (string_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic utf8sd_pkg::result_t mk_res(input logic [utf8sd_pkg::CP_W-1:0] cp,
                                                   input bit repl, input bit rl, input bit se);
        utf8sd_pkg::result_t r;
        r.code_point = cp;
        r.replaced   = repl;
        r.run_last   = rl;
        r.string_end = se;
        return r;
    endfunction

    function automatic byte_row_t plain(input logic [7:0] b, input logic last);
        byte_row_t row;
        row       = '0;
        row.b     = b;
        row.last  = last;
        return row;
    endfunction

    function automatic byte_row_t typed(input logic [7:0] b, input logic last, input int n,
                                        input utf8sd_pkg::result_t r0,
                                        input utf8sd_pkg::result_t r1);
        byte_row_t row;
        row       = plain(b, last);
        row.typed = 1'b1;
        row.n     = n[1:0];
        row.r0    = r0;
        row.r1    = r1;
        return row;
    endfunction

    function automatic void add_row(input byte_row_t row);
        byte_table = {byte_table, row};
    endfunction

    function automatic void queue_expected(input utf8sd_pkg::result_t r);
        exp_cp_q = {exp_cp_q, r};
    endfunction

    function automatic void add_cp(input logic [utf8sd_pkg::CP_W-1:0] cp, input logic repl);
        pred_res[pred_n] = mk_res(cp, repl, 1'b0, 1'b0);
        pred_n++;
    endfunction

    // decode one byte into pred_res/pred_n and advance the mirrored state
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        pred_n = 0;
        if (b <= utf8sd_pkg::ASCII_MAX)
        begin
            // ASCII cuts a pending sequence short
            if (pend_cnt != utf8sd_pkg::PEND_NONE)
            begin
                add_cp(repl_cp, 1'b1);
                pend_cnt = utf8sd_pkg::PEND_NONE;
            end
            add_cp({13'd0, b}, 1'b0);
        end
        else if (b <= utf8sd_pkg::CONT_MAX)
        begin
            if (pend_cnt != utf8sd_pkg::PEND_NONE)
            begin
                acc_cp   = {acc_cp[utf8sd_pkg::CP_W-7:0], b[5:0]};
                pend_cnt = pend_cnt - 2'd1;
                if (pend_cnt == utf8sd_pkg::PEND_NONE)
                    add_cp(acc_cp, 1'b0);
            end
            else
                add_cp(repl_cp, 1'b1);      // stray continuation
        end
        else if (b <= utf8sd_pkg::LEAD2_MAX)
        begin
            pend_cnt = utf8sd_pkg::PEND_ONE;
            acc_cp   = {13'd0, b & utf8sd_pkg::LEAD2_MASK};
        end
        else if (b <= utf8sd_pkg::LEAD3_MAX)
        begin
            pend_cnt = utf8sd_pkg::PEND_TWO;
            acc_cp   = {13'd0, b & utf8sd_pkg::LEAD3_MASK};
        end
        else if (b <= utf8sd_pkg::LEAD4_MAX)
        begin
            pend_cnt = utf8sd_pkg::PEND_THREE;
            acc_cp   = {13'd0, b & utf8sd_pkg::LEAD4_MASK};
        end
        else
        begin
            add_cp(repl_cp, 1'b1);          // 0xF8 and up
            pend_cnt = utf8sd_pkg::PEND_NONE;
        end

        if (last)
        begin
            if (pend_cnt != utf8sd_pkg::PEND_NONE)
                add_cp(repl_cp, 1'b1);      // unfinished at string end
            pend_cnt = utf8sd_pkg::PEND_NONE;
            acc_cp   = '0;
        end

        if (pred_n > 0)
        begin
            pred_res[pred_n-1].run_last   = 1'b1;
            pred_res[pred_n-1].string_end = last;
        end
    endfunction

    task automatic report_mismatch(input string what, input utf8sd_pkg::result_t got,
                                   input utf8sd_pkg::result_t want);
        err_count++;
        $display("mismatch: %s at result %0d: got %h/%b/%b/%b, want %h/%b/%b/%b",
                 what, cps_seen, got.code_point, got.replaced, got.run_last, got.string_end,
                 want.code_point, want.replaced, want.run_last, want.string_end);
    endtask

    // one input transfer; called just after the clock rises
    task automatic send_byte(input byte_row_t row);
        int gap;
        int k;
        gap = fast_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= row.b;
        string_last <= row.last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        decode_byte(row.b, row.last);
        if (row.typed)
        begin
            if (row.n > 0)
                queue_expected(row.r0);
            if (row.n > 1)
                queue_expected(row.r1);
        end
        else
        begin
            for (k = 0; k < pred_n; k++)
                queue_expected(pred_res[k]);
        end
    endtask

    // stop sending, let every expected code point arrive, then idle for a tail
    task automatic drain;
        in_valid <= 1'b0;
        while (exp_cp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [utf8sd_pkg::CP_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        repl_cp = v;
    endtask

    // mostly well-formed characters with random payload, some truncated, some noise
    task automatic send_random_group;
        int          kind;
        int          len;
        int          ncont;
        int          k;
        logic [31:0] r;
        logic [31:0] c;
        logic [7:0]  lead;
        bit          fin;
        kind = $urandom_range(0, 9);
        r    = $urandom;
        if (kind <= 7)
        begin
            if (kind <= 5)
            begin
                len   = $urandom_range(1, 4);
                ncont = len - 1;
            end
            else
            begin
                len   = $urandom_range(2, 4);
                ncont = $urandom_range(0, len - 2);
            end
            case (len)
                1:       lead = {1'b0, r[6:0]};
                2:       lead = {3'b110, r[4:0]};
                3:       lead = {4'b1110, r[3:0]};
                default: lead = {5'b11110, r[2:0]};
            endcase
            fin = ($urandom_range(0, 5) == 0);
            if (ncont == 0)
                send_byte(plain(lead, fin));
            else
            begin
                send_byte(plain(lead, $urandom_range(0, 15) == 0));
                for (k = 0; k < ncont; k++)
                begin
                    c = $urandom;
                    send_byte(plain({2'b10, c[5:0]},
                                    (k == ncont - 1) ? fin : ($urandom_range(0, 15) == 0)));
                end
            end
        end
        else
            send_byte(plain(r[7:0], $urandom_range(0, 3) == 0));
    endtask

    task automatic check_result;
        utf8sd_pkg::result_t e;
        utf8sd_pkg::result_t got;
        got = mk_res(code_point, replaced, run_last, string_end);
        if (exp_cp_q.size() == 0)
            report_mismatch("unexpected result", got, '0);
        else
        begin
            e = exp_cp_q.pop_front();
            if (got !== e)
                report_mismatch("result", got, e);
        end
        cps_seen++;
    endtask

    // output side: random stall before each transfer, one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                gap      = LONG_HOLD;
                hold_out = 1'b0;
            end
            else
                gap = fast_mode ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            check_result();
        end
    end

    initial
    begin
        int                          p;
        int                          start;
        logic [utf8sd_pkg::CP_W-1:0] v;
        logic [31:0]                 rv;

        // directed bytes, replacement at its reset value '?'
        add_row(typed(8'h00, 1'b0, 1, mk_res(21'h00, 1'b0, 1'b1, 1'b0), '0));
        add_row(typed(8'h7F, 1'b1, 1, mk_res(21'h7F, 1'b0, 1'b1, 1'b1), '0));
        add_row(typed(8'h80, 1'b0, 1,                                           // stray
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b0), '0));
        add_row(typed(8'hBF, 1'b1, 1,
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b1), '0));
        add_row(typed(8'hFF, 1'b0, 1,                                           // invalid
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b0), '0));
        add_row(typed(8'hF8, 1'b1, 1,
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b1), '0));
        add_row(plain(8'hC2, 1'b0));                               // two byte form
        add_row(plain(8'hA9, 1'b0));
        add_row(plain(8'hE2, 1'b0));                               // three byte form
        add_row(plain(8'h82, 1'b0));
        add_row(plain(8'hAC, 1'b1));
        add_row(plain(8'hF7, 1'b0));                               // largest code point
        add_row(plain(8'hBF, 1'b0));
        add_row(plain(8'hBF, 1'b0));
        add_row(plain(8'hBF, 1'b0));
        add_row(plain(8'hC0, 1'b0));                               // overlong, accepted
        add_row(plain(8'h80, 1'b0));
        add_row(plain(8'hE0, 1'b0));                               // ASCII cuts it short
        add_row(typed(8'h41, 1'b0, 2, mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b0, 1'b0),
                      mk_res(21'h41, 1'b0, 1'b1, 1'b0)));
        add_row(plain(8'hC3, 1'b0));                               // new lead drops it
        add_row(plain(8'hF0, 1'b0));
        add_row(typed(8'hFF, 1'b0, 1,                                           // invalid drops it
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b0), '0));
        add_row(typed(8'hDF, 1'b1, 1,                                           // open at string end
                      mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b1, 1'b1), '0));
        add_row(plain(8'hE1, 1'b0));
        add_row(typed(8'h7F, 1'b1, 2, mk_res(utf8sd_pkg::REPL_RESET, 1'b1, 1'b0, 1'b0),
                      mk_res(21'h7F, 1'b0, 1'b1, 1'b1)));

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (byte_table[i])
            send_byte(byte_table[i]);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            rv = $urandom;
            case (p)
                0:       v = '0;
                1:       v = {utf8sd_pkg::CP_W{1'b1}};
                4:       v = 21'h00FFFD;
                7:       v = utf8sd_pkg::REPL_RESET;
                default: v = rv[utf8sd_pkg::CP_W-1:0];
            endcase
            write_repl(v);
            fast_mode = (p == 2 || p == 5);
            // the output backs up while input keeps coming
            if (p == 3)
                hold_out = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_ITEMS)
                send_random_group();
        end

        drain();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8sd_decode.sv
hdl/utf8sd_result_queue.sv
hdl/utf8_stream_decoder.sv
tb/sv/tb.sv
